FILE: src/sbct_pkg.sv
// ----------------------------------------------------------------------------
// sbct_pkg: shared constants for the swept box collision test
// Wall codes and default widths.
// ----------------------------------------------------------------------------
`default_nettype none
package sbct_pkg;
    localparam int FracBits   = 16;
    localparam int CoordWidth = 32;
    localparam int RegIndexW  = 1;
    localparam int NumLanes   = 3;

    localparam logic [RegIndexW-1:0] RegMoverWidth  = 1'd0;
    localparam logic [RegIndexW-1:0] RegMoverHeight = 1'd1;

    localparam logic [1:0] WallNone  = 2'd0;
    localparam logic [1:0] WallLeft  = 2'd1;
    localparam logic [1:0] WallRight = 2'd2;
    localparam logic [1:0] WallTop   = 2'd3;

    localparam int LaneLeft  = 0;
    localparam int LaneRight = 1;
    localparam int LaneTop   = 2;
endpackage
`default_nettype wire

FILE: src/sbct_if.sv
// ----------------------------------------------------------------------------
// sbct_if: request and response channels
// Valid/ready channels carrying a move request and a collision response.
// ----------------------------------------------------------------------------
`default_nettype none
interface sbct_req_if #(
    parameter int COORD_WIDTH = sbct_pkg::CoordWidth
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] old_x;
    logic signed [COORD_WIDTH-1:0] old_y;
    logic signed [COORD_WIDTH-1:0] new_x;
    logic signed [COORD_WIDTH-1:0] new_y;
    logic signed [COORD_WIDTH-1:0] box_x;
    logic signed [COORD_WIDTH-1:0] box_y;
    logic        [COORD_WIDTH-2:0] box_width;
    logic        [COORD_WIDTH-2:0] box_height;

    modport source (output valid, old_x, old_y, new_x, new_y, box_x, box_y,
                    box_width, box_height, input ready);
    modport sink   (input valid, old_x, old_y, new_x, new_y, box_x, box_y,
                    box_width, box_height, output ready);
endinterface

interface sbct_rsp_if #(
    parameter int FRAC_BITS = sbct_pkg::FracBits
);
    logic               valid;
    logic               ready;
    logic               hit;
    logic [1:0]         wall;
    logic [FRAC_BITS:0] hit_time;

    modport source (output valid, hit, wall, hit_time, input ready);
    modport sink   (input valid, hit, wall, hit_time, output ready);
endinterface
`default_nettype wire

FILE: src/sbct_div_cell.sv
// ----------------------------------------------------------------------------
// sbct_div_cell: one quotient bit for each wall lane
// Restoring division step on three lanes, context passed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module sbct_div_cell #(
    parameter int W = 36,
    parameter int F = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     valid_in,
    input  wire logic [sbct_pkg::NumLanes-1:0][W-1:0]     rem_in,
    input  wire logic [sbct_pkg::NumLanes-1:0][W-1:0]     den_in,
    input  wire logic [sbct_pkg::NumLanes-1:0][F-1:0]     quo_in,
    input  wire logic [sbct_pkg::NumLanes-1:0]            ok_in,
    input  wire logic [sbct_pkg::NumLanes-1:0][4*W-1:0]   ctx_in,
    output logic                                          valid_out,
    output logic [sbct_pkg::NumLanes-1:0][W-1:0]          rem_out,
    output logic [sbct_pkg::NumLanes-1:0][W-1:0]          den_out,
    output logic [sbct_pkg::NumLanes-1:0][F-1:0]          quo_out,
    output logic [sbct_pkg::NumLanes-1:0]                 ok_out,
    output logic [sbct_pkg::NumLanes-1:0][4*W-1:0]        ctx_out
);
    logic [sbct_pkg::NumLanes-1:0][W-1:0] rem_next;
    logic [sbct_pkg::NumLanes-1:0][F-1:0] quo_next;
    logic [W-1:0]                         shifted;

    always_comb
    begin
        shifted = '0;
        for (int i = 0; i < sbct_pkg::NumLanes; i++)
        begin
            shifted = {rem_in[i][W-2:0], 1'b0};
            if (shifted >= den_in[i])
            begin
                rem_next[i] = shifted - den_in[i];
                quo_next[i] = {quo_in[i][F-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted;
                quo_next[i] = {quo_in[i][F-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            den_out <= den_in;
            quo_out <= quo_next;
            ok_out  <= ok_in;
            ctx_out <= ctx_in;
        end
    end
endmodule
`default_nettype wire

FILE: src/swept_box_collision_test.sv
// ----------------------------------------------------------------------------
// swept_box_collision_test: swept box against static box, three walls
// Widens the box by the mover size, finds entry times and picks the earliest.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req     | in        | old/new corner, box corner and size
//  rsp     | out       | hit, wall code, hit time
//  wr_*    | in        | mover_width (0), mover_height (1)
//
// One request per cycle while no response waits unaccepted. The pipe is one setup
// stage, one divider cell per quotient bit, a multiply stage and a compare stage,
// then the output register. The whole pipe holds while a response waits
// unaccepted. Reset clears the valid bits and loads 10.0 into both sizes.
`default_nettype none
module swept_box_collision_test #(
    parameter int FRAC_BITS   = sbct_pkg::FracBits,
    parameter int COORD_WIDTH = sbct_pkg::CoordWidth
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    sbct_req_if.sink                              req,
    sbct_rsp_if.source                            rsp,
    input  wire logic                             wr_en,
    input  wire logic [sbct_pkg::RegIndexW-1:0]   wr_index,
    input  wire logic [COORD_WIDTH-2:0]           wr_data
);
    localparam int W  = COORD_WIDTH + 4;
    localparam int F  = FRAC_BITS;
    localparam int NL = sbct_pkg::NumLanes;
    localparam int PW = W + F + 1;

    logic [COORD_WIDTH-2:0] mover_width_reg;
    logic [COORD_WIDTH-2:0] mover_height_reg;
    logic                   advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mover_width_reg  <= (COORD_WIDTH-1)'(655360);
            mover_height_reg <= (COORD_WIDTH-1)'(655360);
        end
        else if (wr_en)
        begin
            case (wr_index)
                sbct_pkg::RegMoverWidth:  mover_width_reg  <= wr_data;
                sbct_pkg::RegMoverHeight: mover_height_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // setup: widened box, walls, moves
    logic signed [W-1:0] ox, oy, dx, dy, ax, ay, axr, ayb;
    logic signed [W-1:0] num [NL];
    logic signed [W-1:0] den [NL];
    logic [NL-1:0][W-1:0]   rem0, den0;
    logic [NL-1:0]          ok0;
    logic [NL-1:0][4*W-1:0] ctx0;

    always_comb
    begin
        ox  = W'(req.old_x);
        oy  = W'(req.old_y);
        dx  = W'(req.new_x) - ox;
        dy  = W'(req.new_y) - oy;
        ax  = W'(req.box_x) - W'({1'b0, mover_width_reg});
        ay  = W'(req.box_y) + W'({1'b0, mover_height_reg});
        axr = ax + W'({1'b0, req.box_width}) + W'({1'b0, mover_width_reg});
        ayb = ay - W'({1'b0, req.box_height}) - W'({1'b0, mover_height_reg});
        num[sbct_pkg::LaneLeft]  = ax - ox;
        den[sbct_pkg::LaneLeft]  = dx;
        num[sbct_pkg::LaneRight] = axr - ox;
        den[sbct_pkg::LaneRight] = dx;
        num[sbct_pkg::LaneTop]   = ay - oy;
        den[sbct_pkg::LaneTop]   = dy;
        // context: origin, other-axis move, span low, span high
        ctx0[sbct_pkg::LaneLeft]  = {oy, dy, ayb, ay};
        ctx0[sbct_pkg::LaneRight] = {oy, dy, ayb, ay};
        ctx0[sbct_pkg::LaneTop]   = {ox, dx, ax, axr};
        for (int i = 0; i < NL; i++)
        begin
            // flip signs so the divisor is not negative
            if (den[i] < 0)
            begin
                rem0[i] = -num[i];
                den0[i] = -den[i];
            end
            else
            begin
                rem0[i] = num[i];
                den0[i] = den[i];
            end
            ok0[i] = !rem0[i][W-1] && ($signed(rem0[i]) < $signed(den0[i]));
        end
    end

    logic [F:0]                    cv;
    logic [F:0][NL-1:0][W-1:0]     crem, cden;
    logic [F:0][NL-1:0][F-1:0]     cquo;
    logic [F:0][NL-1:0]            cok;
    logic [F:0][NL-1:0][4*W-1:0]   cctx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv[0] <= 1'b0;
        end
        else if (advance)
        begin
            cv[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            crem[0] <= rem0;
            cden[0] <= den0;
            cquo[0] <= '0;
            cok[0]  <= ok0;
            cctx[0] <= ctx0;
        end
    end

    for (genvar g = 0; g < F; g++)
    begin : g_cell
        sbct_div_cell #(.W(W), .F(F)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (cv[g]),
            .rem_in    (crem[g]),
            .den_in    (cden[g]),
            .quo_in    (cquo[g]),
            .ok_in     (cok[g]),
            .ctx_in    (cctx[g]),
            .valid_out (cv[g+1]),
            .rem_out   (crem[g+1]),
            .den_out   (cden[g+1]),
            .quo_out   (cquo[g+1]),
            .ok_out    (cok[g+1]),
            .ctx_out   (cctx[g+1])
        );
    end

    // multiply: time times other-axis move
    logic                        mul_valid_reg;
    logic signed [PW-1:0]        prod_reg [NL];
    logic [NL-1:0][F-1:0]        mul_tq_reg;
    logic [NL-1:0]               mul_ok_reg;
    logic [NL-1:0][3*W-1:0]      mul_ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_valid_reg <= cv[F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NL; i++)
            begin
                prod_reg[i]    <= $signed({1'b0, cquo[F][i]}) *
                                  $signed(cctx[F][i][3*W-1:2*W]);
                mul_tq_reg[i]  <= cquo[F][i];
                mul_ok_reg[i]  <= cok[F][i];
                mul_ctx_reg[i] <= {cctx[F][i][4*W-1:3*W], cctx[F][i][2*W-1:0]};
            end
        end
    end

    // compare: contact coordinate strictly inside the span
    logic signed [PW-1:0]  cc;
    logic                  cmp_valid_reg;
    logic [NL-1:0][F-1:0]  cmp_tq_reg;
    logic [NL-1:0]         cmp_ok_reg;
    logic [NL-1:0]         cmp_ok_next;

    always_comb
    begin
        cc = '0;
        for (int i = 0; i < NL; i++)
        begin
            cc = PW'($signed(mul_ctx_reg[i][3*W-1:2*W])) + (prod_reg[i] >>> F);
            cmp_ok_next[i] = mul_ok_reg[i]
                && (cc > PW'($signed(mul_ctx_reg[i][2*W-1:W])))
                && (cc < PW'($signed(mul_ctx_reg[i][W-1:0])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cmp_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmp_tq_reg <= mul_tq_reg;
            cmp_ok_reg <= cmp_ok_next;
        end
    end

    // select earliest; ties go to the lane tested first
    logic [F:0] best;
    logic [1:0] wall_sel;

    always_comb
    begin
        best     = {1'b1, {F{1'b0}}};
        wall_sel = sbct_pkg::WallNone;
        if (cmp_ok_reg[sbct_pkg::LaneLeft])
        begin
            best     = {1'b0, cmp_tq_reg[sbct_pkg::LaneLeft]};
            wall_sel = sbct_pkg::WallLeft;
        end
        if (cmp_ok_reg[sbct_pkg::LaneRight] && ({1'b0, cmp_tq_reg[sbct_pkg::LaneRight]} < best))
        begin
            best     = {1'b0, cmp_tq_reg[sbct_pkg::LaneRight]};
            wall_sel = sbct_pkg::WallRight;
        end
        if (cmp_ok_reg[sbct_pkg::LaneTop] && ({1'b0, cmp_tq_reg[sbct_pkg::LaneTop]} < best))
        begin
            best     = {1'b0, cmp_tq_reg[sbct_pkg::LaneTop]};
            wall_sel = sbct_pkg::WallTop;
        end
    end

    logic             out_valid_reg;
    logic             hit_reg;
    logic [1:0]       wall_reg;
    logic [F:0]       time_reg;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cmp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg  <= (wall_sel != sbct_pkg::WallNone);
            wall_reg <= wall_sel;
            time_reg <= best;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.hit      = hit_reg;
    assign rsp.wall     = wall_reg;
    assign rsp.hit_time = time_reg;
endmodule
`default_nettype wire
